// ===== src/stg_pkg.sv =====
package stg_pkg;

  localparam int SineTableDepth = 1024;
  localparam int SineTableWidth = 16;

  localparam int CfgRegCount = 3;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 64;

  localparam logic [CfgIndexWidth-1:0] CFG_X_AXIS = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_Y_AXIS = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_Z_AXIS = 2'd2;

  // pi/2 in Q62 and 2*pi in Q28
  localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
  localparam logic [30:0] TwoPiQ28 = 31'h6487ED51;

  // Pipeline depth from accept to the output register.
  localparam int PipeDepth = 6;

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Restoring unsigned division; used only while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded quarter-wave entry for angle x (radians, Q62), full scale 2^(width-1).
  function automatic logic [63:0] sine_series(logic [63:0] x, int width);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] full;
    logic [63:0] dnm;
    x2 = mul_q62(x, x);
    term = x;
    sum = x;
    for (int k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        dnm = 64'(2 * k) * 64'(2 * k + 1);
        term = div_u64(mul_q62(term, x2), dnm);
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    full = 64'd1 << (width - 1);
    e = (sum + (64'd1 << (62 - width))) >> (63 - width);
    if (e > full) begin
      e = full;
    end
    return e;
  endfunction

endpackage

// ===== src/sinusoidal_trajectory_generator.sv =====
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_time_value (Q16.16 s)
// out     | output     | out_valid/out_stall| out_position_*, out_velocity_* (Q23.8)
// cfg     | input     | cfg_we             | cfg_index, cfg_data (per-axis setting)
//
// One beat enters per cycle while in_stall is low; a result reaches the outputs
// through the angle, table read, product, rounding, 2*pi scaling and output stages.
// rst_n clears the axis settings and all valid bits; payload is not reset.
// out_stall freezes the whole pipeline only while a result is held at the output;
// in_stall is raised only while a result waits at the output under stall.
module sinusoidal_trajectory_generator #(
  parameter int SINE_TABLE_DEPTH = stg_pkg::SineTableDepth,
  parameter int SINE_TABLE_WIDTH = stg_pkg::SineTableWidth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] in_time_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_position_z,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic signed [31:0] out_velocity_z,
  input  logic cfg_we,
  input  logic [stg_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [stg_pkg::CfgDataWidth-1:0] cfg_data
);

  localparam int Lat = stg_pkg::PipeDepth;

  logic [63:0] x_set_r, y_set_r, z_set_r;
  logic [Lat-1:0] vld_r;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_set_r <= '0;
      y_set_r <= '0;
      z_set_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stg_pkg::CFG_X_AXIS: x_set_r <= cfg_data;
        stg_pkg::CFG_Y_AXIS: y_set_r <= cfg_data;
        stg_pkg::CFG_Z_AXIS: z_set_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !(vld_r[Lat-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  stg_axis #(.DEPTH(SINE_TABLE_DEPTH), .WIDTH(SINE_TABLE_WIDTH)) u_axis_x (
    .clk(clk), .en(en), .time_value(in_time_value), .setting(x_set_r),
    .position_r(out_position_x), .velocity_r(out_velocity_x)
  );
  stg_axis #(.DEPTH(SINE_TABLE_DEPTH), .WIDTH(SINE_TABLE_WIDTH)) u_axis_y (
    .clk(clk), .en(en), .time_value(in_time_value), .setting(y_set_r),
    .position_r(out_position_y), .velocity_r(out_velocity_y)
  );
  stg_axis #(.DEPTH(SINE_TABLE_DEPTH), .WIDTH(SINE_TABLE_WIDTH)) u_axis_z (
    .clk(clk), .en(en), .time_value(in_time_value), .setting(z_set_r),
    .position_r(out_position_z), .velocity_r(out_velocity_z)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_result_from_previous_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[Lat-2]))
    else $error("result appeared without a beat in flight");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== src/stg_rom.sv =====
module stg_rom #(
  parameter int DEPTH = stg_pkg::SineTableDepth,
  parameter int WIDTH = stg_pkg::SineTableWidth,
  localparam int AW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  output logic [WIDTH-1:0] data_r
);

  localparam logic [63:0] QD = stg_pkg::HalfPiQ62 / DEPTH;
  localparam logic [63:0] RD = stg_pkg::HalfPiQ62 % DEPTH;

  logic [WIDTH-1:0] rom_tbl [DEPTH+1];

  for (genvar gi = 0; gi <= DEPTH; gi++) begin : g_tbl
    localparam logic [63:0] X = QD * 64'(gi) + (RD * 64'(gi)) / DEPTH;
    localparam logic [63:0] E = stg_pkg::sine_series(X, WIDTH);
    assign rom_tbl[gi] = E[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= rom_tbl[addr];
    end
  end

endmodule

// ===== src/stg_axis.sv =====
module stg_axis #(
  parameter int DEPTH = stg_pkg::SineTableDepth,
  parameter int WIDTH = stg_pkg::SineTableWidth
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        time_value,
  input  logic [63:0]        setting,
  output logic signed [31:0] position_r,
  output logic signed [31:0] velocity_r
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int PW = WIDTH + 16;
  localparam int VW = WIDTH + 32;

  logic signed [15:0] center;
  logic [15:0] amp;
  logic [15:0] freq;
  logic [15:0] phase;

  assign center = setting[63:48];
  assign amp    = setting[47:32];
  assign freq   = setting[31:16];
  assign phase  = setting[15:0];

  // stage 1: angle in 2^-24 turn
  logic [23:0] p_r, p_nxt;
  logic [31:0] af_r;

  assign p_nxt = 24'({8'd0, freq} * time_value[23:0]) + {phase, 8'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      af_r <= {16'd0, amp} * {16'd0, freq};
    end
  end

  // stage 2: table read (registered in the ROM)
  logic [1:0]    quad, cquad;
  logic [37:0]   idx_w;
  logic [AW-1:0] idx, s_addr, c_addr;
  logic          sneg_r, cneg_r;
  logic [31:0]   af2_r;
  logic [WIDTH-1:0] smag, cmag;

  assign quad  = p_r[23:22];
  assign cquad = quad + 2'd1;
  assign idx_w = (38'(p_r[21:0]) * 38'(DEPTH) + (38'd1 << 21)) >> 22;
  assign idx   = idx_w[AW-1:0];
  assign s_addr = quad[0] ? AW'(DEPTH) - idx : idx;
  assign c_addr = cquad[0] ? AW'(DEPTH) - idx : idx;

  stg_rom #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_sin_rom (
    .clk(clk), .en(en), .addr(s_addr), .data_r(smag)
  );
  stg_rom #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_cos_rom (
    .clk(clk), .en(en), .addr(c_addr), .data_r(cmag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sneg_r <= quad[1];
      cneg_r <= cquad[1];
      af2_r  <= af_r;
    end
  end

  // stage 3: amplitude products
  logic [PW-1:0] pprod_r;
  logic [VW-1:0] vprod_r;
  logic          sneg3_r, cneg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pprod_r <= PW'(amp) * PW'(smag);
      vprod_r <= VW'(af2_r) * VW'(cmag);
      sneg3_r <= sneg_r;
      cneg3_r <= cneg_r;
    end
  end

  // stage 4: round, apply sign to position
  logic [PW:0]   pm_w;
  logic [16:0]   pm;
  logic [VW:0]   vm_w;
  logic signed [18:0] pos_nxt;
  logic signed [18:0] pos_r;
  logic [32:0]   vm1_r;
  logic          cneg4_r;

  assign pm_w = ({1'b0, pprod_r} + ((PW+1)'(1) << (WIDTH - 2))) >> (WIDTH - 1);
  assign pm   = pm_w[16:0];
  assign vm_w = ({1'b0, vprod_r} + ((VW+1)'(1) << (WIDTH - 2))) >> (WIDTH - 1);
  assign pos_nxt = sneg3_r ? 19'(center) - $signed({2'b00, pm})
                           : 19'(center) + $signed({2'b00, pm});

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r   <= pos_nxt;
      vm1_r   <= vm_w[32:0];
      cneg4_r <= cneg3_r;
    end
  end

  // stage 5: scale by 2*pi
  logic [63:0] v2_r;
  logic signed [18:0] pos5_r;
  logic        cneg5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r    <= {31'd0, vm1_r} * {33'd0, stg_pkg::TwoPiQ28};
      pos5_r  <= pos_r;
      cneg5_r <= cneg4_r;
    end
  end

  // stage 6: round and sign velocity
  logic [64:0] vm2_w;
  logic [31:0] vmag;

  assign vm2_w = ({1'b0, v2_r} + (65'd1 << 35)) >> 36;
  assign vmag  = vm2_w[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      position_r <= 32'(pos5_r);
      velocity_r <= cneg5_r ? -$signed(vmag) : $signed(vmag);
    end
  end

endmodule

// ===== tb/sinusoidal_trajectory_generator_tb.sv =====
module sinusoidal_trajectory_generator_tb;
  import stg_pkg::*;

  localparam int Depth = SineTableDepth;
  localparam int Width = SineTableWidth;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } sample_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [31:0] in_time_value;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_position_x;
  logic signed [31:0] out_position_y;
  logic signed [31:0] out_position_z;
  logic signed [31:0] out_velocity_x;
  logic signed [31:0] out_velocity_y;
  logic signed [31:0] out_velocity_z;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  sinusoidal_trajectory_generator uut (.*);

  logic [31:0] quarter_sine [0:Depth];
  logic [63:0] axis_word [0:CfgRegCount-1];
  logic [31:0] time_queue [$];
  sample_t sample_queue [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit driving_on = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("sinusoidal_trajectory_generator regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Magnitude of the sine at a 24-bit turn angle; sign returned in neg.
  function automatic logic [63:0] sine_mag(logic [23:0] p, output bit neg);
    logic [1:0] q;
    logic [63:0] idx;
    q = p[23:22];
    idx = ((64'(p[21:0]) * Depth) + (64'd1 << 21)) >> 22;
    if (idx > Depth) idx = Depth;
    if (q[0]) idx = Depth - idx;
    neg = q[1];
    return 64'(quarter_sine[idx]);
  endfunction

  function automatic sample_t trajectory_at(logic [31:0] t);
    sample_t s;
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic signed [63:0] center;
    logic [63:0] amp, freq, ph, smag, cmag, pm, vm;
    logic [127:0] wide;
    logic [23:0] p;
    bit sneg, cneg;
    for (int a = 0; a < 3; a++) begin
      center = 64'(signed'(axis_word[a][63:48]));
      amp = 64'(axis_word[a][47:32]);
      freq = 64'(axis_word[a][31:16]);
      ph = 64'(axis_word[a][15:0]);
      p = 24'((freq * 64'(t)) + (ph << 8));
      smag = sine_mag(p, sneg);
      cmag = sine_mag(p + 24'h400000, cneg);
      pm = (amp * smag + (64'd1 << (Width - 2))) >> (Width - 1);
      pos[a] = sat32(sneg ? center - $signed(pm) : center + $signed(pm));
      vm = (amp * freq * cmag + (64'd1 << (Width - 2))) >> (Width - 1);
      wide = (128'(vm) * 128'(TwoPiQ28) + (128'd1 << 35)) >> 36;
      vm = wide[63:0];
      vel[a] = sat32(cneg ? -$signed(vm) : $signed(vm));
    end
    s.pos_x = pos[0]; s.pos_y = pos[1]; s.pos_z = pos[2];
    s.vel_x = vel[0]; s.vel_y = vel[1]; s.vel_z = vel[2];
    return s;
  endfunction

  // Quarter-wave ROM from the Taylor series in Q62.
  task automatic build_quarter_sine();
    logic [63:0] step_q, step_r, x, x2, term, sum, e, dnm;
    logic [127:0] prod;
    step_q = HalfPiQ62 / Depth;
    step_r = HalfPiQ62 % Depth;
    for (int i = 0; i <= Depth; i++) begin
      x = step_q * i + (step_r * i) / Depth;
      prod = 128'(x) * 128'(x);
      x2 = prod[125:62];
      term = x;
      sum = x;
      for (int k = 1; k < 40 && term != 0; k++) begin
        dnm = 64'(2 * k) * 64'(2 * k + 1);
        prod = 128'(term) * 128'(x2);
        term = prod[125:62] / dnm;
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      e = (sum + (64'd1 << (62 - Width))) >> (63 - Width);
      if (e > (64'd1 << (Width - 1))) e = 64'd1 << (Width - 1);
      quarter_sine[i] = e[31:0];
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: offer beats from the pending queue, hold while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && in_stall) begin
      // hold the beat
    end else begin
      if (in_valid) beats_sent <= beats_sent + 1;
      if (driving_on && time_queue.size() > 0 && send_gap == 0) begin
        in_valid <= 1;
        in_time_value <= time_queue.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_valid <= 0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end
    end
  end

  // Expectations are formed when the beat is taken, with settings of that time.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sample_queue.push_back(trajectory_at(in_time_value));
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    sample_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_position_x, out_position_y, out_position_z,
             out_velocity_x, out_velocity_y, out_velocity_z};
      if (sample_queue.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = sample_queue.pop_front();
        beats_checked <= beats_checked + 1;
        if (got.pos_x !== want.pos_x) begin
          $error("position_x expected %0d got %0d", want.pos_x, got.pos_x); errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("position_y expected %0d got %0d", want.pos_y, got.pos_y); errors++;
        end
        if (got.pos_z !== want.pos_z) begin
          $error("position_z expected %0d got %0d", want.pos_z, got.pos_z); errors++;
        end
        if (got.vel_x !== want.vel_x) begin
          $error("velocity_x expected %0d got %0d", want.vel_x, got.vel_x); errors++;
        end
        if (got.vel_y !== want.vel_y) begin
          $error("velocity_y expected %0d got %0d", want.vel_y, got.vel_y); errors++;
        end
        if (got.vel_z !== want.vel_z) begin
          $error("velocity_z expected %0d got %0d", want.vel_z, got.vel_z); errors++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      recv_gap <= pick_gap();
    end
  end

  task automatic write_axis(logic [CfgIndexWidth-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx < CfgRegCount) axis_word[idx] = value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    driving_on = 1;
    wait (time_queue.size() == 0 && !in_valid && sample_queue.size() == 0);
    driving_on = 0;
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_axis();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: w[47:32] = 16'd0;
      1: w[31:16] = 16'd0;
      2: w[31:16] = 16'($urandom_range(0, 1024));
      3: w[47:32] = 16'($urandom_range(0, 2048));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 32'h000fffff);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [63:0] extremes [4];
    rst_n = 0;
    in_valid = 0;
    in_time_value = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_X_AXIS;
    cfg_data = 0;
    for (int a = 0; a < CfgRegCount; a++) axis_word[a] = 0;
    build_quarter_sine();
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // reset settings: every output must be zero
    time_queue.push_back(32'h0);
    time_queue.push_back(32'hffffffff);
    drain();

    extremes[0] = 64'h7fff_ffff_ffff_ffff;
    extremes[1] = 64'h8000_ffff_ffff_0000;
    extremes[2] = 64'h0100_0100_0100_4000;
    extremes[3] = 64'hff00_0000_ffff_8000;
    write_axis(CFG_X_AXIS, extremes[0]);
    write_axis(CFG_Y_AXIS, extremes[1]);
    write_axis(CFG_Z_AXIS, extremes[2]);
    // out-of-range index is ignored
    write_axis(2'd3, 64'hdead_beef_dead_beef);
    foreach (extremes[i]) begin
      time_queue.push_back(32'h0);
      time_queue.push_back(32'hffffffff);
      time_queue.push_back(32'h00010000);
      time_queue.push_back(32'h00004000);
      time_queue.push_back(32'h80000000);
      time_queue.push_back(32'h0000c000);
    end
    drain();
    write_axis(CFG_X_AXIS, extremes[3]);
    write_axis(CFG_Y_AXIS, 64'h0);
    write_axis(CFG_Z_AXIS, 64'h8000_0000_0000_ffff);
    for (int i = 0; i < 6; i++) begin
      time_queue.push_back({2'($urandom_range(0, 3)), 14'd0, 16'h0});
    end
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      write_axis(CFG_X_AXIS, rand_axis());
      write_axis(CFG_Y_AXIS, rand_axis());
      write_axis(CFG_Z_AXIS, rand_axis());
      for (int i = 0; i < 160; i++) time_queue.push_back(rand_time());
      if (phase == 4) begin
        driving_on = 1;
        wait (in_valid);
        hold_cycles = 60;
      end
      drain();
    end

    repeat (PipeDepth + 10) @(posedge clk);
    $display("checked %0d result beats over %0d sent beats, 14 setting phases",
             beats_checked, beats_sent);
    if (errors == 0 && sample_queue.size() == 0) begin
      $display("sinusoidal_trajectory_generator regression: pass");
    end else begin
      $display("sinusoidal_trajectory_generator regression: fail");
    end
    $finish;
  end
endmodule
